@@ rtl/sfrsc_pkg.sv @@
// Shared types, constants and frame classification for the serial frame receiver.
package sfrsc_pkg;

    localparam logic [8:0] MaxFrame     = 9'd256;
    localparam logic [8:0] DataFrameLen = 9'd203;
    localparam logic [8:0] OptFrameLen  = 9'd20;

    localparam logic [7:0] HeadA     = 8'h71;
    localparam logic [7:0] HeadB     = 8'h31;
    localparam logic [7:0] HeadC     = 8'hF1;
    localparam logic [8:0] LenAdjust = 9'd3;
    localparam logic [7:0] KindData  = 8'h10;
    localparam logic [7:0] KindExtra = 8'h21;

    localparam int unsigned TDataWidth = 80;
    localparam int unsigned TUserWidth = 4;

    typedef enum logic [2:0] {
        ST_MID      = 3'd0,
        ST_DATA     = 3'd1,
        ST_EXTRA    = 3'd2,
        ST_OPT      = 3'd3,
        ST_OTHER    = 3'd4,
        ST_BAD_HEAD = 3'd5,
        ST_BAD_SUM  = 3'd6,
        ST_OVERFLOW = 3'd7
    } status_t;

    typedef struct packed {
        logic [15:0] bad_header_count;
        logic [15:0] bad_sum_count;
        logic [15:0] good_count;
        logic [15:0] total_count;
        status_t     status;
        logic        frame_done;
        logic        in_frame;
        logic [7:0]  frame_pos;
        logic [7:0]  data_byte;
    } result_t;

    function automatic status_t classify(input logic [8:0] len, input logic [7:0] kind);
        status_t st;
        if (len == DataFrameLen) begin
            if (kind == KindData) begin
                st = ST_DATA;
            end else if (kind == KindExtra) begin
                st = ST_EXTRA;
            end else begin
                st = ST_OTHER;
            end
        end else if (len == OptFrameLen) begin
            st = ST_OPT;
        end else begin
            st = ST_OTHER;
        end
        return st;
    endfunction

endpackage

@@ rtl/sfrsc_core.sv @@
// Frame state, checksum, classification and event counters, one byte per transaction.
module sfrsc_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    output sfrsc_pkg::result_t res
);
    import sfrsc_pkg::*;

    logic [8:0]  byte_count_reg, byte_count_next;
    logic [8:0]  expected_len_reg, expected_len_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  kind_byte_reg, kind_byte_next;
    logic [15:0] starts_seen_reg, starts_seen_next;
    logic [15:0] good_seen_reg, good_seen_next;
    logic [15:0] bad_sum_seen_reg, bad_sum_seen_next;
    logic [15:0] bad_head_seen_reg, bad_head_seen_next;

    logic    taken;
    logic    done;
    status_t status;

    always_comb begin
        byte_count_next    = byte_count_reg;
        expected_len_next  = expected_len_reg;
        running_sum_next   = running_sum_reg;
        kind_byte_next     = kind_byte_reg;
        starts_seen_next   = starts_seen_reg;
        good_seen_next     = good_seen_reg;
        bad_sum_seen_next  = bad_sum_seen_reg;
        bad_head_seen_next = bad_head_seen_reg;
        taken  = 1'b1;
        done   = 1'b0;
        status = ST_MID;

        if (byte_count_reg == 9'd0) begin
            starts_seen_next = starts_seen_reg + 16'd1;
            if (rx_byte != HeadA && rx_byte != HeadB && rx_byte != HeadC) begin
                bad_head_seen_next = bad_head_seen_reg + 16'd1;
                taken  = 1'b0;
                done   = 1'b1;
                status = ST_BAD_HEAD;
            end else begin
                running_sum_next  = rx_byte;
                kind_byte_next    = 8'd0;
                expected_len_next = 9'd0;
                byte_count_next   = 9'd1;
            end
        end else begin
            running_sum_next = running_sum_reg + rx_byte;
            byte_count_next  = byte_count_reg + 9'd1;
            if (byte_count_reg == 9'd1) begin
                expected_len_next = {1'b0, rx_byte} + LenAdjust;
                if (expected_len_next > MaxFrame) begin
                    done            = 1'b1;
                    status          = ST_OVERFLOW;
                    byte_count_next = 9'd0;
                end
            end else begin
                if (byte_count_reg == 9'd3) begin
                    kind_byte_next = rx_byte;
                end
                if (byte_count_next >= expected_len_reg) begin
                    done = 1'b1;
                    if (running_sum_next == 8'd0) begin
                        good_seen_next = good_seen_reg + 16'd1;
                        status         = classify(expected_len_reg, kind_byte_next);
                    end else begin
                        bad_sum_seen_next = bad_sum_seen_reg + 16'd1;
                        status            = ST_BAD_SUM;
                    end
                    byte_count_next = 9'd0;
                end
            end
        end

        res.data_byte        = rx_byte;
        res.frame_pos        = byte_count_reg[7:0];
        res.in_frame         = taken;
        res.frame_done       = done;
        res.status           = status;
        res.total_count      = starts_seen_next;
        res.good_count       = good_seen_next;
        res.bad_sum_count    = bad_sum_seen_next;
        res.bad_header_count = bad_head_seen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg    <= '0;
            expected_len_reg  <= '0;
            running_sum_reg   <= '0;
            kind_byte_reg     <= '0;
            starts_seen_reg   <= '0;
            good_seen_reg     <= '0;
            bad_sum_seen_reg  <= '0;
            bad_head_seen_reg <= '0;
        end else if (accept) begin
            byte_count_reg    <= byte_count_next;
            expected_len_reg  <= expected_len_next;
            running_sum_reg   <= running_sum_next;
            kind_byte_reg     <= kind_byte_next;
            starts_seen_reg   <= starts_seen_next;
            good_seen_reg     <= good_seen_next;
            bad_sum_seen_reg  <= bad_sum_seen_next;
            bad_head_seen_reg <= bad_head_seen_next;
        end
    end

`ifndef SYNTH
    a_count_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_count_reg >= 9'd2) |-> (byte_count_reg < expected_len_reg))
        else $error("byte count reached frame length without closing");

    a_done_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res.frame_done) |=> (byte_count_reg == 9'd0))
        else $error("frame end did not close the frame");

    a_start_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && byte_count_reg == 9'd0) |=>
        (starts_seen_reg == 16'($past(starts_seen_reg) + 16'd1)))
        else $error("frame start not counted");
`endif

endmodule

@@ rtl/sfrsc_out_reg.sv @@
// Result register between the frame logic and the output stream.
module sfrsc_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  sfrsc_pkg::result_t res,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output sfrsc_pkg::result_t out_res
);
    import sfrsc_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

`ifndef SYNTH
    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (valid_reg && !out_ready))
        else $error("input stalled with empty result register");

    a_load_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

@@ rtl/serial_frame_receiver_sum_check_top.sv @@
// Top level of the length-prefixed serial frame receiver with 8-bit sum check.
//
// Usage:
//   s_ channel: one received serial byte per transaction in s_tdata[7:0].
//   m_ channel: one result per input byte. m_tdata carries the echoed byte,
//   its index in the frame and the four wrapping 16-bit event counters;
//   m_tuser carries the in-frame flag and the status code; m_tlast is high
//   on the byte that ends or aborts a frame (good, bad sum, overflow, or a
//   rejected header byte).
//   Each byte's result is registered and on m_ in the cycle after its transaction.
//   Throughput: one byte per cycle unless m_tready stalls; frame checking
//   is a single add/compare pass between the frame state and result register.
//   Reset (aresetn low, synchronous): frame state and all counters clear,
//   the result register empties.
//   Stall: while a result waits on m_tready, s_tready stays high only if
//   that result leaves in the same cycle; otherwise input is held off and
//   no byte or result is lost.
module serial_frame_receiver_sum_check_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // data_byte, frame_pos, total_count, good_count, bad_sum_count, bad_header_count
    output logic [sfrsc_pkg::TDataWidth-1:0]    m_tdata,
    output logic                                m_tlast,  // frame_done
    output logic [sfrsc_pkg::TUserWidth-1:0]    m_tuser   // in_frame, status
);
    import sfrsc_pkg::*;

    logic    accept;
    result_t core_res;
    result_t out_res;

    assign accept = s_tvalid && s_tready;

    sfrsc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rx_byte (s_tdata),
        .res     (core_res)
    );

    sfrsc_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .res       (core_res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.bad_header_count, out_res.bad_sum_count, out_res.good_count,
                      out_res.total_count, out_res.frame_pos, out_res.data_byte};
    assign m_tlast = out_res.frame_done;
    assign m_tuser = {out_res.status, out_res.in_frame};

endmodule

@@ dv/serial_frame_receiver_sum_check_top_tb.sv @@
// Self-checking testbench for the serial frame receiver with 8-bit sum check.
module serial_frame_receiver_sum_check_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfrsc_pkg::*;

    localparam int StallLimit = 4000;
    localparam int PhaseItems = 200;
    localparam int NumRows    = 24;

    typedef struct {
        logic [7:0]  rx;
        bit          typed;
        logic [7:0]  idx;
        logic        inf;
        logic        done;
        status_t     st;
        logic [15:0] tot;
        logic [15:0] good;
        logic [15:0] bsum;
        logic [15:0] bhead;
    } dir_row_t;

    typedef struct {
        bit      typed;
        result_t want;
    } byte_tag_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDataWidth-1:0] m_tdata;
    logic                  m_tlast;
    logic [TUserWidth-1:0] m_tuser;

    // frame tracker
    logic [8:0]  frame_cnt = '0;
    logic [8:0]  frame_len = '0;
    logic [7:0]  frame_sum = '0;
    logic [7:0]  frame_kind = '0;
    logic [15:0] n_starts = '0;
    logic [15:0] n_good = '0;
    logic [15:0] n_badsum = '0;
    logic [15:0] n_badhead = '0;

    byte_tag_t tag_q [$];
    result_t   expect_q [$];

    int n_fail      = 0;
    int n_results   = 0;
    int n_sent      = 0;
    int send_idle   = 0;
    int stall_pct   = 0;
    int idle_cycles = 0;

    dir_row_t dir_tbl [NumRows] = '{
        '{8'h00, 1'b1, 8'd0, 1'b0, 1'b1, ST_BAD_HEAD, 16'd1, 16'd0, 16'd0, 16'd1},
        '{8'hFF, 1'b1, 8'd0, 1'b0, 1'b1, ST_BAD_HEAD, 16'd2, 16'd0, 16'd0, 16'd2},
        '{8'h70, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'h71, 1'b1, 8'd0, 1'b1, 1'b0, ST_MID, 16'd4, 16'd0, 16'd0, 16'd3},
        '{8'h01, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'h00, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'h8E, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'h31, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'hFE, 1'b1, 8'd1, 1'b1, 1'b1, ST_OVERFLOW, 16'd5, 16'd1, 16'd0, 16'd3},
        '{8'hF1, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'hFF, 1'b1, 8'd1, 1'b1, 1'b1, ST_OVERFLOW, 16'd6, 16'd1, 16'd0, 16'd3},
        '{8'hF1, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'h00, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'h0F, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'h71, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'h01, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'h55, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'h55, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'hF0, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'h71, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'h02, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'h71, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'h00, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0},
        '{8'h1C, 1'b0, 8'd0, 1'b0, 1'b0, ST_MID, 16'd0, 16'd0, 16'd0, 16'd0}
    };

    serial_frame_receiver_sum_check_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    function automatic void flag_fail(input string msg);
        if (n_fail < 10) begin
            $display("%s", msg);
        end
        n_fail++;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            flag_fail($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                                n_results, name, want, got));
        end
    endfunction

    // Advances the frame tracker by one received byte and returns the expected result.
    function automatic result_t track_frame_byte(input logic [7:0] b);
        result_t r;
        logic [8:0] pos;
        pos          = frame_cnt;
        r.data_byte  = b;
        r.frame_pos  = pos[7:0];
        r.in_frame   = 1'b1;
        r.frame_done = 1'b0;
        r.status     = ST_MID;
        if (frame_cnt == 9'd0) begin
            n_starts = n_starts + 16'd1;
            if (b != HeadA && b != HeadB && b != HeadC) begin
                n_badhead    = n_badhead + 16'd1;
                r.in_frame   = 1'b0;
                r.frame_done = 1'b1;
                r.status     = ST_BAD_HEAD;
            end else begin
                frame_sum  = b;
                frame_kind = 8'h00;
                frame_len  = 9'd0;
                frame_cnt  = 9'd1;
            end
        end else begin
            frame_sum = frame_sum + b;
            frame_cnt = frame_cnt + 9'd1;
            if (pos == 9'd1) begin
                frame_len = {1'b0, b} + LenAdjust;
                if (frame_len > MaxFrame) begin
                    r.frame_done = 1'b1;
                    r.status     = ST_OVERFLOW;
                    frame_cnt    = 9'd0;
                end
            end else begin
                if (pos == 9'd3) begin
                    frame_kind = b;
                end
                if (frame_cnt >= frame_len) begin
                    r.frame_done = 1'b1;
                    if (frame_sum == 8'h00) begin
                        n_good = n_good + 16'd1;
                        if (frame_len == DataFrameLen) begin
                            r.status = (frame_kind == KindData)  ? ST_DATA :
                                       (frame_kind == KindExtra) ? ST_EXTRA : ST_OTHER;
                        end else if (frame_len == OptFrameLen) begin
                            r.status = ST_OPT;
                        end else begin
                            r.status = ST_OTHER;
                        end
                    end else begin
                        n_badsum = n_badsum + 16'd1;
                        r.status = ST_BAD_SUM;
                    end
                    frame_cnt = 9'd0;
                end
            end
        end
        r.total_count      = n_starts;
        r.good_count       = n_good;
        r.bad_sum_count    = n_badsum;
        r.bad_header_count = n_badhead;
        return r;
    endfunction

    // input side: every accepted byte turns into one expected result
    always @(posedge aclk) begin
        byte_tag_t tag;
        result_t   pred;
        if (aresetn && s_tvalid && s_tready) begin
            pred = track_frame_byte(s_tdata);
            if (tag_q.size() != 0) begin
                tag = tag_q.pop_front();
                expect_q.insert(expect_q.size(), tag.typed ? tag.want : pred);
            end else begin
                expect_q.insert(expect_q.size(), pred);
            end
        end
    end

    // output side
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expect_q.size() == 0) begin
                flag_fail($sformatf("result %0d: no transaction pending, tdata 0x%0h",
                                    n_results, m_tdata));
            end else begin
                want = expect_q.pop_front();
                check_field("data_byte", 16'(want.data_byte), 16'(m_tdata[7:0]));
                check_field("frame_pos", 16'(want.frame_pos), 16'(m_tdata[15:8]));
                check_field("total_count", want.total_count, m_tdata[31:16]);
                check_field("good_count", want.good_count, m_tdata[47:32]);
                check_field("bad_sum_count", want.bad_sum_count, m_tdata[63:48]);
                check_field("bad_header_count", want.bad_header_count, m_tdata[79:64]);
                check_field("in_frame", 16'(want.in_frame), 16'(m_tuser[0]));
                check_field("status", 16'(want.status), 16'(m_tuser[3:1]));
                check_field("frame_done", 16'(want.frame_done), 16'(m_tlast));
            end
            n_results++;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
        byte_tag_t tag;
        tag.typed = typed;
        tag.want  = want;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        tag_q.insert(tag_q.size(), tag);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        n_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expect_q.size() != 0 || tag_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // close any frame left open so the next frame starts aligned
    task automatic sync_frame();
        wait_drained();
        while (frame_cnt != 9'd0) begin
            send_byte(8'h00, 1'b0, '0);
            wait_drained();
        end
    endtask

    // sends the first cut bytes of a frame of length len; lengths past the limit stop
    // after the length byte
    task automatic send_frame(input int len, input logic [7:0] kind, input bit good,
                              input int cut);
        logic [7:0] b;
        logic [7:0] sum;
        int n;
        int i;
        n   = (len > int'(MaxFrame)) ? 2 : len;
        sum = 8'h00;
        if (cut < n) begin
            n = cut;
        end
        for (i = 0; i < n; i++) begin
            if (i == 0) begin
                case ($urandom_range(2))
                    0: begin
                        b = HeadA;
                    end
                    1: begin
                        b = HeadB;
                    end
                    default: begin
                        b = HeadC;
                    end
                endcase
            end else if (i == 1) begin
                b = 8'(len - int'(LenAdjust));
            end else if (i == len - 1) begin
                b = good ? 8'(-sum) : 8'(8'($urandom_range(1, 255)) - sum);
            end else if (i == 3) begin
                b = kind;
            end else begin
                b = 8'($urandom);
            end
            sum = sum + b;
            send_byte(b, 1'b0, '0);
        end
    endtask

    initial begin
        result_t want;
        int k;
        int ph;
        int r;
        int len;
        int mark;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < NumRows; k++) begin
            want.data_byte        = dir_tbl[k].rx;
            want.frame_pos        = dir_tbl[k].idx;
            want.in_frame         = dir_tbl[k].inf;
            want.frame_done       = dir_tbl[k].done;
            want.status           = dir_tbl[k].st;
            want.total_count      = dir_tbl[k].tot;
            want.good_count       = dir_tbl[k].good;
            want.bad_sum_count    = dir_tbl[k].bsum;
            want.bad_header_count = dir_tbl[k].bhead;
            send_byte(dir_tbl[k].rx, dir_tbl[k].typed, want);
        end

        for (ph = 0; ph < 4; ph++) begin
            wait_drained();
            send_idle = (ph == 1) ? 45 : (ph == 3) ? 17 : 0;
            stall_pct <= (ph == 2) ? 45 : (ph == 3) ? 17 : 0;
            sync_frame();
            mark = n_sent;
            case (ph)
                0: begin
                    send_frame(int'(DataFrameLen), KindData, 1'b1, 999);
                end
                1: begin
                    send_frame(int'(DataFrameLen), KindExtra, 1'b1, 999);
                end
                2: begin
                    send_frame(int'(MaxFrame), 8'($urandom), 1'b1, 999);
                end
                default: begin
                    send_frame(int'(DataFrameLen), 8'($urandom), 1'b1, 999);
                end
            endcase
            send_frame(int'(OptFrameLen), 8'($urandom), 1'b1, 999);
            while (n_sent - mark < PhaseItems) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    send_byte(8'($urandom), 1'b0, '0);
                end else if (r < 14) begin
                    send_frame($urandom_range(257, 258), 8'h00, 1'b1, 999);
                end else if (r < 22) begin
                    send_frame(int'(OptFrameLen), 8'($urandom), $urandom_range(9) != 0, 999);
                end else if (r < 28) begin
                    len = $urandom_range(3, 24);
                    send_frame(len, 8'($urandom), 1'b1, $urandom_range(1, len - 1));
                end else begin
                    len = $urandom_range(3, 24);
                    send_frame(len, 8'($urandom), $urandom_range(4) != 0, 999);
                end
            end
        end

        wait_drained();
        stall_pct <= 0;
        repeat (4) @(posedge aclk);
        if (expect_q.size() != 0) begin
            flag_fail($sformatf("%0d results never arrived", expect_q.size()));
        end
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
